FILE: hdl/utf16_to_utf8_encoder_assert.svh
// assertion macros shared by the transcoder rtl
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define U2U8_ASSERT(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define U2U8_NEVER(lbl, expr, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define U2U8_ASSERT(lbl, prop, clk, rstn)
`define U2U8_NEVER(lbl, expr, clk, rstn)
`endif

`endif

FILE: hdl/u2u8_pkg.sv
// shared types and constants of the utf-16 to utf-8 transcoder
package u2u8_pkg;

  localparam int unsigned UnitW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxData    = 4;
  localparam int unsigned CntW       = 3;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [5:0] HighSurTag  = 6'b110110;
  localparam logic [5:0] LowSurTag   = 6'b110111;
  localparam logic [4:0] SurTag      = 5'b11011;

  localparam logic [7:0] Lead2       = 8'hc0;
  localparam logic [7:0] Lead3       = 8'he0;
  localparam logic [7:0] Lead4       = 8'hf0;
  localparam logic [7:0] ContMark    = 8'h80;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // one classified unit waiting for the byte emitter
  typedef struct packed {
    logic [MaxData-1:0][ByteW-1:0] bytes;    // bytes[0] goes out first
    logic [CntW-1:0]               data_cnt; // 0..4 data bytes
    logic                          term;     // zero terminator follows
  } job_t;

endpackage

FILE: hdl/utf16_to_utf8_encoder.sv
// utf-16 code units in, utf-8 bytes out, with a job queue between front and back
// an accepted unit's job is queued, then loaded into the emitter before its bytes go out
// throughput: one unit per cycle while each unit yields one byte and the output is ready;
//   one byte per cycle goes out while ready; multi-byte units hold input via the job queue
// reset: asynchronous active low; clears the held surrogate, queue and emitter
module utf16_to_utf8_encoder #(
  parameter int unsigned QueueDepth = u2u8_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,   // last_unit
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o    // [0] is_terminator
);

  u2u8_pkg::job_t push_job, pop_job;
  logic           push, pop, q_full, q_empty;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .code_unit_i (s_axis_tdata_i),
    .last_unit_i (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_job)
  );

  u2u8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_job),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (m_axis_tdata_o),
    .run_last_o      (m_axis_tlast_o),
    .is_terminator_o (m_axis_tuser_o)
  );

endmodule

FILE: hdl/u2u8_front.sv
// front end: accepts code units, tracks surrogate pairing, builds byte jobs
module u2u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       code_unit_i,
  input  logic              last_unit_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u2u8_pkg::job_t    job_o
);

  logic       pend_q, pend_d;
  logic [9:0] hi_q, hi_d;
  logic       is_high, is_low, is_sur, pair, accept;
  logic [20:0] dw;
  logic [15:0] w;

  assign w       = code_unit_i;
  assign is_high = (w[15:10] == u2u8_pkg::HighSurTag);
  assign is_low  = (w[15:10] == u2u8_pkg::LowSurTag);
  assign is_sur  = (w[15:11] == u2u8_pkg::SurTag);
  assign pair    = pend_q && is_low;
  assign dw      = u2u8_pkg::SuppBase + {1'b0, hi_q, w[9:0]};

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    job_o       = '0;
    job_o.term  = last_unit_i;
    if (pair) begin
      job_o.bytes[0] = u2u8_pkg::Lead4 | {5'd0, dw[20:18]};
      job_o.bytes[1] = u2u8_pkg::ContMark | {2'd0, dw[17:12]};
      job_o.bytes[2] = u2u8_pkg::ContMark | {2'd0, dw[11:6]};
      job_o.bytes[3] = u2u8_pkg::ContMark | {2'd0, dw[5:0]};
      job_o.data_cnt = 3'd4;
    end else if (w[15:7] == 9'd0) begin
      job_o.bytes[0] = w[7:0];
      job_o.data_cnt = 3'd1;
    end else if (w[15:11] == 5'd0) begin
      job_o.bytes[0] = u2u8_pkg::Lead2 | {3'd0, w[10:6]};
      job_o.bytes[1] = u2u8_pkg::ContMark | {2'd0, w[5:0]};
      job_o.data_cnt = 3'd2;
    end else if (!is_sur) begin
      job_o.bytes[0] = u2u8_pkg::Lead3 | {4'd0, w[15:12]};
      job_o.bytes[1] = u2u8_pkg::ContMark | {2'd0, w[11:6]};
      job_o.bytes[2] = u2u8_pkg::ContMark | {2'd0, w[5:0]};
      job_o.data_cnt = 3'd3;
    end
    // surrogates not forming a pair give no data bytes
  end

  assign push_o = accept && ((job_o.data_cnt != '0) || last_unit_i);

  always_comb begin
    pend_d = pend_q;
    hi_d   = hi_q;
    if (accept) begin
      pend_d = !last_unit_i && !pair && is_high;
      hi_d   = pend_d ? w[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      hi_q   <= '0;
    end else begin
      pend_q <= pend_d;
      hi_q   <= hi_d;
    end
  end

endmodule

FILE: hdl/u2u8_queue.sv
// short first-word-fall-through queue of byte jobs
`include "utf16_to_utf8_encoder_assert.svh"

module u2u8_queue #(
  parameter int unsigned Depth = u2u8_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u8_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u2u8_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u2u8_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  `U2U8_NEVER(a_push_when_full, push_i && full_o, clk_i, rst_ni)
  `U2U8_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), clk_i, rst_ni)

endmodule

FILE: hdl/u2u8_back.sv
// back end: walks one job and sends its bytes one beat at a time
`include "utf16_to_utf8_encoder_assert.svh"

module u2u8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  u2u8_pkg::job_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           is_terminator_o
);

  u2u8_pkg::job_t  job_q, job_d;
  logic            busy_q, busy_d;
  logic [2:0]      idx_q, idx_d;
  logic [2:0]      last_idx;
  logic            fire, final_beat;

  assign last_idx   = job_q.data_cnt + {2'd0, job_q.term} - 3'd1;
  assign final_beat = (idx_q == last_idx);
  assign fire       = busy_q && out_ready_i;
  assign pop_o      = !q_empty_i && (!busy_q || (fire && final_beat));

  assign out_valid_o     = busy_q;
  assign is_terminator_o = (idx_q == job_q.data_cnt);
  assign run_last_o      = final_beat;
  assign out_byte_o      = is_terminator_o ? 8'd0 : job_q.bytes[idx_q[1:0]];

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      job_d  = q_data_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire) begin
      if (final_beat) busy_d = 1'b0;
      else idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  `U2U8_ASSERT(a_term_is_last, is_terminator_o && busy_q |-> run_last_o, clk_i, rst_ni)
  `U2U8_ASSERT(a_idx_in_job, busy_q |-> idx_q <= last_idx, clk_i, rst_ni)

endmodule
